// File: rtl/dq_pkg.sv
// shared types and constants of the double-ended queue
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPCODE_W       = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int LEN_W          = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

`default_nettype wire

// File: rtl/dq_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// top level of the double-ended queue: sequencer, pointers and value registers
`default_nettype none

// bounded double-ended queue of signed values kept in a ring buffer
// command channel: a word (opcode, value) is taken at a clock edge where start
//   is high and busy is low
// opcodes: push front, push back, pop front, pop back, clear, query; codes six
//   and seven act as query
// result channel: done is high for exactly one cycle with status, first_value,
//   last_value and length; the receiver cannot stall, so the word must be taken
//   in that cycle
// one result word per command word, in command order
// latency: the result shows one cycle after the command is taken for push,
//   clear, query and any rejected or ignored command, and two cycles after it
//   for a pop that leaves the queue non-empty
// throughput: one command per cycle, or one per two cycles for such a pop; the
//   extra cycle is the registered read of the ring ram that fetches the new
//   front or back word, and busy is high during it
// front and back values are also kept in registers, so pushes need no read
// reset clears pointers, count and the strobe; ram contents are left as they are
// and are only read at occupied slots

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [dq_pkg::OPCODE_W-1:0]       opcode,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] value,
  output logic                                   busy,
  output logic                                   done,
  output logic      [dq_pkg::STATUS_W-1:0]       status,
  output logic signed [dq_pkg::VALUE_W-1:0]      first_value,
  output logic signed [dq_pkg::VALUE_W-1:0]      last_value,
  output logic      [dq_pkg::LEN_W-1:0]          length
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // ring index helpers
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  // stored word sign-extended, low bits onto the result port
  function automatic logic [dq_pkg::VALUE_W-1:0] to_port(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] ext;
    ext = 64'(signed'(d));
    return ext[dq_pkg::VALUE_W-1:0];
  endfunction

  // sequencer state
  dq_pkg::state_t      state, state_next;
  logic                pend_front, pend_front_next;   // which end the read refills

  // queue state
  logic [IDX_W-1:0]      front, front_next;           // slot of the front word
  logic [IDX_W-1:0]      back, back_next;             // slot one past the back word
  logic [CNT_W-1:0]      count, count_next;
  logic [DATA_WIDTH-1:0] first_reg, first_reg_next;
  logic [DATA_WIDTH-1:0] last_reg, last_reg_next;

  // result registers
  logic                         done_next;
  logic [dq_pkg::STATUS_W-1:0]  status_next;
  logic [dq_pkg::VALUE_W-1:0]   first_value_next;
  logic [dq_pkg::VALUE_W-1:0]   last_value_next;
  logic [dq_pkg::LEN_W-1:0]     length_next;

  // ram access
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] wval;
  logic [IDX_W-1:0]      idx;
  logic                  is_full, is_empty;
  dq_pkg::status_t       stat;

  assign value_ext = 64'(value);
  assign wval      = value_ext[DATA_WIDTH-1:0];
  assign is_full   = (count == CNT_FULL);
  assign is_empty  = (count == '0);
  assign busy      = (state == dq_pkg::S_READ);

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wval),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dq_pkg::S_IDLE;
      pend_front <= 1'b0;
      front      <= '0;
      back       <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      pend_front <= pend_front_next;
      front      <= front_next;
      back       <= back_next;
      count      <= count_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_reg   <= first_reg_next;
    last_reg    <= last_reg_next;
    status      <= status_next;
    first_value <= first_value_next;
    last_value  <= last_value_next;
    length      <= length_next;
  end

  always_comb begin
    state_next      = state;
    pend_front_next = pend_front;
    front_next      = front;
    back_next       = back;
    count_next      = count;
    first_reg_next  = first_reg;
    last_reg_next   = last_reg;
    done_next       = 1'b0;
    status_next     = status;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = back;
    mem_raddr       = front;
    idx             = front;
    stat            = dq_pkg::ST_OK;

    case (state)
      dq_pkg::S_IDLE: begin
        if (start) begin
          case (dq_pkg::op_t'(opcode))
            dq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                stat = dq_pkg::ST_FULL;
              end else begin
                idx            = idx_dec(front);
                front_next     = idx;
                mem_we         = 1'b1;
                mem_waddr      = idx;
                count_next     = count + CNT_ONE;
                first_reg_next = wval;
                if (is_empty) begin
                  last_reg_next = wval;
                end
              end
            end
            dq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                stat = dq_pkg::ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = back;
                back_next     = idx_inc(back);
                count_next    = count + CNT_ONE;
                last_reg_next = wval;
                if (is_empty) begin
                  first_reg_next = wval;
                end
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                stat = dq_pkg::ST_EMPTY;
              end else begin
                idx        = idx_inc(front);
                front_next = idx;
                count_next = count - CNT_ONE;
                // fetch the new front word unless the queue runs dry
                if (count != CNT_ONE) begin
                  mem_re          = 1'b1;
                  mem_raddr       = idx;
                  pend_front_next = 1'b1;
                  state_next      = dq_pkg::S_READ;
                end
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                stat = dq_pkg::ST_EMPTY;
              end else begin
                idx        = idx_dec(back);
                back_next  = idx;
                count_next = count - CNT_ONE;
                if (count != CNT_ONE) begin
                  mem_re          = 1'b1;
                  mem_raddr       = idx_dec(idx);
                  pend_front_next = 1'b0;
                  state_next      = dq_pkg::S_READ;
                end
              end
            end
            dq_pkg::OP_CLEAR: begin
              front_next = '0;
              back_next  = '0;
              count_next = '0;
            end
            default: begin
              // query and unused codes leave everything as it is
            end
          endcase
          status_next = stat;
          if (state_next == dq_pkg::S_IDLE) begin
            done_next = 1'b1;
          end
        end
      end
      dq_pkg::S_READ: begin
        // ram word for the end that moved is now valid
        if (pend_front) begin
          first_reg_next = mem_rdata;
        end else begin
          last_reg_next = mem_rdata;
        end
        done_next  = 1'b1;
        state_next = dq_pkg::S_IDLE;
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  // result word follows the state after the operation
  always_comb begin
    if (count_next == '0) begin
      first_value_next = '0;
      last_value_next  = '0;
    end else begin
      first_value_next = to_port(first_reg_next);
      last_value_next  = to_port(last_reg_next);
    end
    length_next = dq_pkg::LEN_W'(count_next);
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the double-ended queue with a shadow deque and random command words

module tb_top;

  localparam int RING        = dq_pkg::DEPTH_DEF;
  localparam int IDX_W       = $clog2(RING);
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int WORD_BUDGET = 850;
  localparam int MAX_GAP     = 12;

  // opcodes outside the enum, the block treats them as query
  localparam logic [dq_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [dq_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  // bias of a stretch of random commands
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  // one result word as the block reports it
  typedef struct packed {
    logic [dq_pkg::STATUS_W-1:0] status;
    logic [dq_pkg::VALUE_W-1:0]  first_value;
    logic [dq_pkg::VALUE_W-1:0]  last_value;
    logic [dq_pkg::LEN_W-1:0]    length;
  } reply_t;

  // shadow deque: tracks the ring contents and queues the reply each command word should give
  class deque_tracker;
    logic [dq_pkg::VALUE_W-1:0] ring_mem [RING];
    // ring size is a power of two, so the indices wrap on their own
    logic [IDX_W-1:0]           head_idx = '0;
    logic [IDX_W-1:0]           tail_idx = '0;
    logic [dq_pkg::LEN_W-1:0]   fill = '0;
    reply_t                     pending_replies[$];
    int unsigned                mismatches = 0;

    function void note_command(logic [dq_pkg::OPCODE_W-1:0] op,
                               logic [dq_pkg::VALUE_W-1:0] val);
      reply_t r;
      r.status = dq_pkg::ST_OK;
      case (op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (fill >= RING) begin
            r.status = dq_pkg::ST_FULL;
          end else begin
            head_idx = head_idx - 1'b1;
            ring_mem[head_idx] = val;
            fill = fill + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (fill >= RING) begin
            r.status = dq_pkg::ST_FULL;
          end else begin
            ring_mem[tail_idx] = val;
            tail_idx = tail_idx + 1'b1;
            fill = fill + 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            head_idx = head_idx + 1'b1;
            fill = fill - 1'b1;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            tail_idx = tail_idx - 1'b1;
            fill = fill - 1'b1;
          end
        end
        dq_pkg::OP_CLEAR: begin
          head_idx = '0;
          tail_idx = '0;
          fill = '0;
        end
        default: ;
      endcase
      r.length = fill;
      if (fill != 0) begin
        r.first_value = ring_mem[head_idx];
        r.last_value  = ring_mem[tail_idx - 1'b1];
      end else begin
        r.first_value = '0;
        r.last_value  = '0;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result word with nothing outstanding: status %0d first %h last %h len %0d",
                   $realtime, got.status, got.first_value, got.last_value, got.length);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.first_value !== want.first_value ||
          got.last_value !== want.last_value || got.length !== want.length) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch status %0d/%0d first %h/%h last %h/%h len %0d/%0d (exp/act)",
                   $realtime, want.status, got.status, want.first_value, got.first_value,
                   want.last_value, got.last_value, want.length, got.length);
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic [dq_pkg::OPCODE_W-1:0]       opcode;
  logic signed [dq_pkg::VALUE_W-1:0] value;
  logic                              busy;
  logic                              done;
  logic [dq_pkg::STATUS_W-1:0]       status;
  logic signed [dq_pkg::VALUE_W-1:0] first_value;
  logic signed [dq_pkg::VALUE_W-1:0] last_value;
  logic [dq_pkg::LEN_W-1:0]          length;

  deque_tracker shadow;
  int unsigned  words_sent = 0;
  int unsigned  cycle_count = 0;
  bit           quiet_run = 1'b0;

  double_ended_queue u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .first_value (first_value),
    .last_value  (last_value),
    .length      (length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // monitor: old values seen at the rising edge, result checked before the new word is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1)
        shadow.check_reply({status, first_value, last_value, length});
      if (start === 1'b1 && busy === 1'b0)
        shadow.note_command(opcode, value);
    end
  end

  // idle cycles before a word, none at all during a quiet run
  function automatic int unsigned idle_gap();
    if (quiet_run)
      return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // values lean on the extremes, otherwise all 32 bits at random
  function automatic logic [dq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(dq_pkg::VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(dq_pkg::VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dq_pkg::OPCODE_W-1:0] pick_push();
    return $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
  endfunction

  function automatic logic [dq_pkg::OPCODE_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
  endfunction

  function automatic logic [dq_pkg::OPCODE_W-1:0] pick_op(mix_t mix);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        push_pct = 80;
        pop_pct  = 14;
      end
      MIX_DRAIN: begin
        push_pct = 14;
        pop_pct  = 80;
      end
      default: begin
        push_pct = 46;
        pop_pct  = 46;
      end
    endcase
    if (r < push_pct)
      return pick_push();
    if (r < push_pct + pop_pct)
      return pick_pop();
    if (r < push_pct + pop_pct + 2)
      return dq_pkg::OP_CLEAR;
    case ($urandom_range(0, 3))
      0:       return OP_SPARE_6;
      1:       return OP_SPARE_7;
      default: return dq_pkg::OP_QUERY;
    endcase
  endfunction

  // entered and left at a falling edge; opcode and value carry noise while start is low
  task automatic send_word(input logic [dq_pkg::OPCODE_W-1:0] op,
                           input logic [dq_pkg::VALUE_W-1:0] val);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) begin
        opcode = $urandom;
        value  = $urandom;
        @(negedge clk);
      end
    end
    start  = 1'b1;
    opcode = op;
    value  = val;
    // word taken at the first edge that sees busy low
    do
      @(posedge clk);
    while (busy !== 1'b0);
    words_sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    mix_t        mix;
    int unsigned run_len;
    rst    = 1'b1;
    start  = 1'b0;
    opcode = '0;
    value  = '0;
    shadow = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: empty queue reports, spare opcodes, extremes, sole element pops, clear
    send_word(dq_pkg::OP_QUERY, '0);
    send_word(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_word(dq_pkg::OP_POP_BACK, '1);
    send_word(OP_SPARE_6, 32'h5555_5555);
    send_word(OP_SPARE_7, 32'hAAAA_AAAA);
    send_word(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(dq_pkg::OP_POP_FRONT, '0);
    send_word(dq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_word(dq_pkg::OP_POP_BACK, '0);
    send_word(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(dq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_word(dq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
    send_word(dq_pkg::OP_QUERY, 32'hDEAD_BEEF);
    // the first two pops leave the queue non-empty and go through the read state; the third empties it
    send_word(dq_pkg::OP_POP_FRONT, '0);
    send_word(dq_pkg::OP_POP_BACK, '0);
    send_word(dq_pkg::OP_POP_BACK, '0);
    send_word(dq_pkg::OP_PUSH_BACK, 32'h8000_0001);
    send_word(dq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFE);
    send_word(dq_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_word(dq_pkg::OP_QUERY, '0);
    send_word(dq_pkg::OP_PUSH_BACK, 32'h1357_9BDF);
    send_word(dq_pkg::OP_POP_FRONT, '0);

    // fill past full, so pushes get rejected, in chunks with and without idling
    for (int i = 0; i < RING + 6; i++) begin
      if (i % 32 == 0)
        quiet_run = ($urandom_range(0, 2) == 0);
      send_word(pick_push(), pick_value());
    end
    // drain past empty, so pops get ignored
    for (int i = 0; i < RING + 6; i++) begin
      if (i % 32 == 0)
        quiet_run = ($urandom_range(0, 2) == 0);
      send_word(pick_pop(), pick_value());
    end

    // random stretches, each with its own bias and idling
    while (words_sent < WORD_BUDGET) begin
      case ($urandom_range(0, 2))
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      quiet_run = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(10, 60);
      for (int i = 0; i < run_len; i++)
        send_word(pick_op(mix), pick_value());
    end
    start = 1'b0;

    // wait for the last result word, then let the clock run on to catch strays
    while (shadow.pending_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
tb/tb_top.sv
